/* src/tkm_pkg.sv */
// Shared types, constants and helpers for the top-k magnitude tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tkm_pkg;

  localparam int TOP_COUNT = 5;
  localparam int IDX_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int RANK_W    = 4;
  localparam int OBJ_W     = 17;
  localparam int AMT_W     = 32;
  localparam int INDEX_W   = 16;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [OBJ_W-1:0] EMPTY_OBJECT  = '1;
  localparam logic [AMT_W-1:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

  typedef struct packed {
    logic             category;
    logic [OBJ_W-1:0] object;
    logic [AMT_W-1:0] amount;
  } entry_t;

  // One wavefront moving down the chain: an insert carrying an entry, or a clear.
  typedef struct packed {
    logic   valid;
    logic   clear;
    entry_t ent;
  } tok_t;

  localparam entry_t EMPTY_ENTRY = '{category: 1'b0, object: EMPTY_OBJECT,
                                     amount: MINUS_ONE_Q16};

  // Two's complement absolute value; the most negative code maps to 2^31.
  function automatic logic [AMT_W-1:0] magnitude(input logic [AMT_W-1:0] raw);
    magnitude = raw[AMT_W-1] ? (~raw + AMT_W'(1)) : raw;
  endfunction

endpackage

/* src/tkm_cell.sv */
// One rank of the sorted list: holds a slot and swaps with the passing entry.
// Depends on tkm_pkg.
`timescale 1ns / 1ps

module tkm_cell import tkm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  tok_t   tok_in,
  output tok_t   tok_out,
  output entry_t slot
);

  logic take;

  assign take = !tok_in.clear && (magnitude(tok_in.ent.amount) > magnitude(slot.amount));

  // The displaced entry carries on; on a tie or a loss the candidate itself does.
  always_ff @(posedge clk) begin
    tok_out.clear <= tok_in.clear;
    tok_out.ent   <= (tok_in.valid && take) ? slot : tok_in.ent;
    if (rst) begin
      slot          <= EMPTY_ENTRY;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        if (tok_in.clear) begin
          slot <= EMPTY_ENTRY;
        end else if (take) begin
          slot <= tok_in.ent;
        end
      end
    end
  end

endmodule

/* src/top_k_magnitude_tracker.sv */
// Top-k magnitude tracker: a chain of tkm_cell ranks plus a read-out sequencer.
// Depends on tkm_pkg and tkm_cell.
`timescale 1ns / 1ps

// Insert and clear items are taken one per cycle while no read is pending or active.
// Each starts a wave that passes down the rank registers in order, rank 0 first, and
// the list settles once the last wave has left the chain. A read item waits for the
// chain to drain, then enters the reading state and emits TOP_COUNT items, one per
// cycle when the output is ready, rank 0 first, with tlast on the final one. No input
// item is taken from the acceptance of a read until its last item is loaded into the
// output register.
module top_k_magnitude_tracker import tkm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // object_type[0], object_index[16:1], value[48:17]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // rank[3:0], entry_category[4], entry_object[21:5],
                                 // entry_amount[53:22]
  output logic        m_tlast
);

  tok_t   tok_chain [TOP_COUNT+1];
  entry_t slots     [TOP_COUNT];

  logic              s_accept;
  logic              chain_busy;
  logic              rd_pend;
  logic              reading;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_final;
  logic              out_load;
  logic [RANK_W-1:0] out_rank;
  entry_t            out_ent;
  logic              out_last;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = !rd_pend && !reading;

  always_comb begin
    tok_chain[0].valid        = s_accept && (s_tuser == KIND_INSERT || s_tuser == KIND_CLEAR);
    tok_chain[0].clear        = (s_tuser == KIND_CLEAR);
    tok_chain[0].ent.category = s_tdata[0];
    tok_chain[0].ent.object   = {1'b0, s_tdata[INDEX_W:1]};
    tok_chain[0].ent.amount   = s_tdata[INDEX_W+AMT_W:INDEX_W+1];
  end

  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_cell
    tkm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[k]),
      .tok_out (tok_chain[k+1]),
      .slot    (slots[k])
    );
  end

  always_comb begin
    chain_busy = 1'b0;
    for (int k = 1; k <= TOP_COUNT; k++) begin
      chain_busy = chain_busy | tok_chain[k].valid;
    end
  end

  assign rd_final = (rd_idx == IDX_W'(TOP_COUNT - 1));
  assign out_load = reading && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      reading  <= 1'b0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept && s_tuser == KIND_READ) begin
        rd_pend <= 1'b1;
      end
      // The read starts only once every wave in flight has left the chain.
      if (rd_pend && !chain_busy) begin
        rd_pend <= 1'b0;
        reading <= 1'b1;
        rd_idx  <= '0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (rd_final) begin
          reading <= 1'b0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rank <= RANK_W'(rd_idx);
      out_ent  <= slots[rd_idx];
      out_last <= rd_final;
    end
  end

  assign m_tdata = {2'b00, out_ent.amount, out_ent.object, out_ent.category, out_rank};
  assign m_tlast = out_last;

  a_read_on_idle_chain: assert property (@(posedge clk) disable iff (rst)
    reading |-> !chain_busy)
    else $error("read out overlaps a wave in the chain");

  a_read_via_pending: assert property (@(posedge clk) disable iff (rst)
    $rose(reading) |-> $past(rd_pend))
    else $error("read out started without a pending read");

  a_pend_excl: assert property (@(posedge clk) disable iff (rst)
    !(rd_pend && reading))
    else $error("pending read and active read at once");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[RANK_W-1:0] == RANK_W'(TOP_COUNT - 1)))
    else $error("tlast on a rank other than the final one");

  for (genvar k = 0; k < TOP_COUNT - 1; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      (!chain_busy && !tok_chain[0].valid) |=>
        (chain_busy || magnitude(slots[k].amount) >= magnitude(slots[k+1].amount)))
      else $error("list out of magnitude order while idle");
  end

endmodule

/* dv/tkm_checker.sv */
// Checker for the top-k magnitude tracker: watches both stream channels, keeps its own
// copy of the ranked list and compares every read-out item against it. Depends on tkm_pkg.
`timescale 1ns / 1ps

module tkm_checker import tkm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // object_type[0], object_index[16:1], value[48:17]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // rank[3:0], entry_category[4], entry_object[21:5],
                                 // entry_amount[53:22]
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              category;
    logic [OBJ_W-1:0]  object;
    logic [AMT_W-1:0]  amount;
    logic              last;
  } slot_item_t;

  entry_t     ranked [TOP_COUNT];
  slot_item_t readout_q [$];
  int         fail_count = 0;

  assign errors = fail_count;

  // Absolute value as an unsigned number, so the most negative code ranks above all.
  function automatic logic [AMT_W-1:0] abs_q16(input logic [AMT_W-1:0] raw);
    abs_q16 = raw[AMT_W-1] ? (AMT_W'(0) - raw) : raw;
  endfunction

  task automatic report_mismatch(input string what, input logic [AMT_W-1:0] want,
                                 input logic [AMT_W-1:0] seen);
    $display("%0t ns: %s mismatch, expected %h, observed %h", $time, what, want, seen);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    entry_t     carry;
    entry_t     spare;
    slot_item_t want;
    slot_item_t seen;
    if (rst) begin
      foreach (ranked[k]) ranked[k] = EMPTY_ENTRY;
      readout_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = '{rank: m_tdata[3:0], category: m_tdata[4], object: m_tdata[21:5],
                 amount: m_tdata[53:22], last: m_tlast};
        if (readout_q.size() == 0) begin
          report_mismatch("unrequested read-out item, amount", '0, seen.amount);
        end else begin
          want = readout_q.pop_front();
          if (seen.rank != want.rank)
            report_mismatch("rank", AMT_W'(want.rank), AMT_W'(seen.rank));
          if (seen.category != want.category)
            report_mismatch("entry_category", AMT_W'(want.category),
                            AMT_W'(seen.category));
          if (seen.object != want.object)
            report_mismatch("entry_object", AMT_W'(want.object), AMT_W'(seen.object));
          if (seen.amount != want.amount)
            report_mismatch("entry_amount", want.amount, seen.amount);
          if (seen.last != want.last)
            report_mismatch("tlast", AMT_W'(want.last), AMT_W'(seen.last));
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          KIND_INSERT: begin
            carry = '{category: s_tdata[0], object: {1'b0, s_tdata[16:1]},
                      amount: s_tdata[48:17]};
            // The candidate sinks down the list; whatever falls off the end is lost.
            for (int k = 0; k < TOP_COUNT; k++) begin
              if (abs_q16(carry.amount) > abs_q16(ranked[k].amount)) begin
                spare     = ranked[k];
                ranked[k] = carry;
                carry     = spare;
              end
            end
          end
          KIND_CLEAR: begin
            foreach (ranked[k]) ranked[k] = EMPTY_ENTRY;
          end
          KIND_READ: begin
            for (int k = 0; k < TOP_COUNT; k++)
              readout_q.push_back('{rank: RANK_W'(k), category: ranked[k].category,
                                    object: ranked[k].object, amount: ranked[k].amount,
                                    last: (k == TOP_COUNT - 1)});
          end
          default: ;
        endcase
      end
    end
    pending <= readout_q.size();
  end

endmodule

/* dv/top_k_magnitude_tracker_tb.sv */
// Testbench top for the top-k magnitude tracker: clock, reset, item stimulus and verdict.
// Depends on tkm_pkg, top_k_magnitude_tracker and tkm_checker.
`timescale 1ns / 1ps

module top_k_magnitude_tracker_tb;
  import tkm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tlast;
  int          errors;
  int          pending;

  logic        hold_req;
  logic        no_idle;
  logic [31:0] recent_amount;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  top_k_magnitude_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  tkm_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // Offers one item and returns at the edge where it is taken.
  task automatic send_item(input logic [1:0] kind, input logic obj_type,
                           input logic [15:0] index, input logic [31:0] amount);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, amount, index, obj_type};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_gap();
    if (!no_idle && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Waits with the input quiet until every requested read-out has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Candidates cluster around 1.0 and repeat earlier magnitudes so that ties and the
  // empty-slot threshold are hit often, with some full-range values mixed in.
  function automatic logic [31:0] pick_amount();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1: begin
        v = $urandom_range(32'h0001_0001, 32'h0004_0000);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        v = $urandom;
        if (v == 32'h8000_0000) v = 32'h8000_0001;
      end
      3: v = $urandom_range(1) ? recent_amount : -recent_amount;
      4: begin
        v = $urandom_range(0, 32'h0001_0000);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001;
    endcase
    recent_amount = v;
    return v;
  endfunction

  initial begin
    int          pick;
    logic [1:0]  kind;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = KIND_INSERT;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    recent_amount = 32'h0001_8000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, the 1.0 threshold, ties, field extremes, overflow, clear.
    send_item(KIND_READ,   1'b0, 16'd0,     32'd0);
    send_item(KIND_INSERT, 1'b1, 16'd1,     32'h0001_0000);
    send_item(KIND_INSERT, 1'b1, 16'd2,     32'hFFFF_0000);
    send_item(KIND_INSERT, 1'b0, 16'd0,     32'd0);
    send_item(KIND_INSERT, 1'b1, 16'd65535, 32'h0001_0001);
    send_item(KIND_INSERT, 1'b0, 16'd3,     32'hFFFE_FFFF);
    send_item(KIND_INSERT, 1'b1, 16'd4,     32'h7FFF_FFFF);
    send_item(KIND_INSERT, 1'b0, 16'd5,     32'h8000_0001);
    send_item(KIND_READ,   1'b1, 16'd65535, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 1'b1, 16'd6,     32'h0100_0000);
    send_item(KIND_READ,   1'b0, 16'd0,     32'd0);
    send_item(KIND_INSERT, 1'b1, 16'd7,     32'h0003_0000);
    send_item(KIND_INSERT, 1'b0, 16'd8,     32'hFFFD_0000);
    send_item(KIND_INSERT, 1'b1, 16'd9,     32'h0000_0001);
    send_item(KIND_INSERT, 1'b0, 16'd10,    32'h0002_0000);
    send_item(KIND_READ,   1'b0, 16'd0,     32'd0);
    send_item(KIND_CLEAR,  1'b1, 16'd65535, 32'h7FFF_FFFF);
    send_item(KIND_READ,   1'b0, 16'd0,     32'd0);
    send_item(KIND_INSERT, 1'b0, 16'd11,    32'hFFFF_FFFF);
    send_item(KIND_INSERT, 1'b1, 16'd12,    32'h0001_0002);
    send_item(KIND_READ,   1'b0, 16'd0,     32'd0);
    drain();

    // Random: the first items run into a long output hold so the block backs up.
    hold_req <= 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i == 50) no_idle = 1'b1;
      if (i == 100) begin
        no_idle = 1'b0;
        drain();
      end
      pick = $urandom_range(99);
      if (i < 12)
        kind = (i % 3 == 2) ? KIND_READ : KIND_INSERT;
      else if (pick < 76)
        kind = KIND_INSERT;
      else if (pick < 90)
        kind = KIND_READ;
      else if (pick < 95)
        kind = KIND_CLEAR;
      else
        kind = KIND_UNUSED;
      send_item(kind, 1'($urandom_range(1)), 16'($urandom_range(65535)), pick_amount());
      if (i < 12) continue;
      idle_gap();
    end
    send_item(KIND_READ, 1'b0, 16'd0, 32'd0);
    drain();
    repeat (4 * TOP_COUNT) @(posedge clk);
    if (errors == 0)
      $display("top_k_magnitude_tracker verification clean");
    else
      $display("top_k_magnitude_tracker verification failed");
    $finish;
  end

  // Output side: random back-pressure, one long hold on request, none in the quiet stretch.
  initial begin
    int  count;
    logic held;
    m_tready = 1'b0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held     = 1'b1;
        m_tready <= 1'b0;
        count    = 0;
        while (count < HOLD_CYCLES) begin
          @(posedge clk);
          count++;
        end
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("top_k_magnitude_tracker verification failed");
    $finish;
  end

endmodule
